### rtl/core/sfr_pkg.sv
// Shared types and constants for the stuffed frame receiver.
// No dependencies; compile first.
package sfr_pkg;

    localparam int BYTE_W     = 8;
    localparam int ADDR_W     = 7;
    localparam int CRC_W      = 16;
    localparam int COUNT_W    = 9;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    localparam logic [COUNT_W-1:0] FRAME_OVERHEAD = COUNT_W'(5);

    localparam logic [BYTE_W-1:0] START_BYTE_RST  = BYTE_W'(127);
    localparam logic [ADDR_W-1:0] OWN_ADDRESS_RST = ADDR_W'(0);
    localparam logic [CRC_W-1:0]  CRC_SEED_RST    = CRC_W'(65535);
    localparam logic [CRC_W-1:0]  CRC_POLY_RST    = CRC_W'(32773);

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_START_BYTE  = 2'd0,
        CFG_OWN_ADDRESS = 2'd1,
        CFG_CRC_SEED    = 2'd2,
        CFG_CRC_POLY    = 2'd3
    } t_cfg_idx;

    typedef enum logic [2:0] {
        EV_NONE      = 3'd0,
        EV_FRAME_OK  = 3'd1,
        EV_CRC_ERR   = 3'd2,
        EV_ADDR_MISS = 3'd3,
        EV_RESYNC    = 3'd4,
        EV_IDLE_DROP = 3'd5
    } t_sfr_event;

    typedef struct packed {
        logic [BYTE_W-1:0] start_byte;
        logic [ADDR_W-1:0] own_address;
        logic [CRC_W-1:0]  crc_seed;
        logic [CRC_W-1:0]  crc_poly;
    } t_sfr_cfg;

    typedef struct packed {
        logic               byte_valid;
        logic [BYTE_W-1:0]  frame_byte;
        logic [COUNT_W-1:0] byte_index;
        t_sfr_event         event_res;
        logic               sequence_bit;
        logic [BYTE_W-1:0]  payload_length;
    } t_sfr_result;

endpackage

### rtl/core/sfr_in_if.sv
// Input word channel: valid/ready handshake carrying one raw received byte.
// Depends on sfr_pkg.
interface sfr_in_if;
    import sfr_pkg::*;

    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

### rtl/core/sfr_out_if.sv
// Result word channel: valid/ready handshake carrying one receiver result.
// Depends on sfr_pkg.
interface sfr_out_if;
    import sfr_pkg::*;

    logic        valid;
    logic        ready;
    t_sfr_result data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

### rtl/core/sfr_crc_byte.sv
// Byte-wide MSB-first CRC-16 update with programmable polynomial.
// Depends on sfr_pkg.
module sfr_crc_byte (
    input  logic [sfr_pkg::CRC_W-1:0]  i_crc,
    input  logic [sfr_pkg::BYTE_W-1:0] i_byte,
    input  logic [sfr_pkg::CRC_W-1:0]  i_poly,
    output logic [sfr_pkg::CRC_W-1:0]  o_crc
);
    import sfr_pkg::*;

    always_comb begin
        logic [CRC_W-1:0] c;
        c = i_crc ^ {i_byte, {(CRC_W-BYTE_W){1'b0}}};
        for (int k = 0; k < BYTE_W; k++) begin
            if (c[CRC_W-1]) begin
                c = {c[CRC_W-2:0], 1'b0} ^ i_poly;
            end else begin
                c = {c[CRC_W-2:0], 1'b0};
            end
        end
        o_crc = c;
    end
endmodule

### rtl/core/sfr_deframer.sv
// Frame state and destuffing/end-of-frame logic for one byte per advance.
// Depends on sfr_pkg and sfr_crc_byte.
module sfr_deframer (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_adv,
    input  logic [sfr_pkg::BYTE_W-1:0]  i_byte,
    input  sfr_pkg::t_sfr_cfg           i_cfg,
    output sfr_pkg::t_sfr_result        o_res
);
    import sfr_pkg::*;

    logic [COUNT_W-1:0] r_count, n_count;
    logic               r_pend, n_pend;
    logic [COUNT_W-1:0] r_flen, n_flen;
    logic [CRC_W-1:0]   r_crc, n_crc;
    logic [CRC_W-1:0]   r_rcrc, n_rcrc;
    logic [BYTE_W-1:0]  r_addr, n_addr;

    logic               restart;
    logic [CRC_W-1:0]   crc_in;
    logic [CRC_W-1:0]   crc_out;

    assign restart = (r_count != '0) && r_pend && (i_byte != i_cfg.start_byte);
    assign crc_in  = restart ? i_cfg.crc_seed : r_crc;

    sfr_crc_byte u_crc (
        .i_crc  (crc_in),
        .i_byte (i_byte),
        .i_poly (i_cfg.crc_poly),
        .o_crc  (crc_out)
    );

    always_comb begin
        logic               store;
        logic [COUNT_W-1:0] idx;
        logic [COUNT_W:0]   idx_p2;
        n_count = r_count;
        n_pend  = r_pend;
        n_flen  = r_flen;
        n_crc   = r_crc;
        n_rcrc  = r_rcrc;
        n_addr  = r_addr;
        o_res   = '0;
        store   = 1'b0;
        idx     = r_count;

        if (r_count == '0) begin
            if (i_byte == i_cfg.start_byte) begin
                n_pend = 1'b0;
                n_flen = '0;
                n_crc  = i_cfg.crc_seed;
                n_rcrc = '0;
                n_addr = '0;
                store  = 1'b1;
            end else begin
                o_res.event_res = EV_IDLE_DROP;
            end
        end else begin
            if (r_pend) begin
                n_pend = 1'b0;
                if (restart) begin
                    idx             = COUNT_W'(1);
                    n_flen          = '0;
                    n_crc           = i_cfg.crc_seed;
                    n_rcrc          = '0;
                    o_res.event_res = EV_RESYNC;
                end
                store = 1'b1;
            end else if (i_byte == i_cfg.start_byte) begin
                n_pend = 1'b1;
            end else begin
                store = 1'b1;
            end
        end

        idx_p2 = {1'b0, idx} + (COUNT_W+1)'(2);
        if (store) begin
            o_res.byte_valid = 1'b1;
            o_res.frame_byte = i_byte;
            o_res.byte_index = idx;
            if (idx == COUNT_W'(1)) begin
                n_addr = i_byte;
                n_crc  = crc_out;
            end else if (idx == COUNT_W'(2)) begin
                n_crc  = crc_out;
                n_flen = {1'b0, i_byte} + FRAME_OVERHEAD;
            end else if (idx >= COUNT_W'(3) && n_flen != '0) begin
                if (idx_p2 < {1'b0, n_flen}) begin
                    n_crc = crc_out;
                end else if (idx_p2 == {1'b0, n_flen}) begin
                    n_rcrc = {n_rcrc[CRC_W-1:BYTE_W], i_byte};
                end else begin
                    n_rcrc = {i_byte, n_rcrc[BYTE_W-1:0]};
                end
            end
            n_count = idx + COUNT_W'(1);
        end

        if (r_count != '0 && n_flen != '0 && n_count == n_flen) begin
            o_res.payload_length = BYTE_W'(n_flen - FRAME_OVERHEAD);
            if ((n_addr & i_cfg.start_byte) != {1'b0, i_cfg.own_address}) begin
                o_res.event_res = EV_ADDR_MISS;
            end else if (n_crc != n_rcrc) begin
                o_res.event_res = EV_CRC_ERR;
            end else begin
                o_res.event_res    = EV_FRAME_OK;
                o_res.sequence_bit = n_addr[BYTE_W-1];
            end
            n_count = '0;
            n_pend  = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_pend  <= 1'b0;
            r_flen  <= '0;
            r_crc   <= CRC_SEED_RST;
            r_rcrc  <= '0;
            r_addr  <= '0;
        end else if (i_adv) begin
            r_count <= n_count;
            r_pend  <= n_pend;
            r_flen  <= n_flen;
            r_crc   <= n_crc;
            r_rcrc  <= n_rcrc;
            r_addr  <= n_addr;
        end
    end
endmodule

### rtl/core/stuffed_frame_receiver_crc16.sv
// Path: input register, combinational deframer and CRC-16 update, then result register.
// Throughput: one word per cycle while the result channel is not stalled.
// Every input word yields exactly one result word.
// Reset: synchronous active low; clears frame state, seeds the CRC register, loads
// register defaults and empties both pipeline registers.
// Depends on sfr_pkg, sfr_in_if, sfr_out_if and sfr_deframer.
module stuffed_frame_receiver_crc16 (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    sfr_in_if.sink                          i_rx,
    sfr_out_if.source                       o_res,
    input  logic                            i_cfg_we,
    input  logic [sfr_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [sfr_pkg::CFG_DATA_W-1:0]  i_cfg_data
);
    import sfr_pkg::*;

    t_sfr_cfg          r_cfg;
    logic              r_in_vld;
    logic [BYTE_W-1:0] r_in_byte;
    logic              r_out_vld;
    t_sfr_result       r_out;
    t_sfr_result       n_out;
    logic              adv;

    assign adv        = r_in_vld && (!r_out_vld || o_res.ready);
    assign i_rx.ready = !r_in_vld || adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.start_byte  <= START_BYTE_RST;
            r_cfg.own_address <= OWN_ADDRESS_RST;
            r_cfg.crc_seed    <= CRC_SEED_RST;
            r_cfg.crc_poly    <= CRC_POLY_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_START_BYTE:  r_cfg.start_byte  <= i_cfg_data[BYTE_W-1:0];
                CFG_OWN_ADDRESS: r_cfg.own_address <= i_cfg_data[ADDR_W-1:0];
                CFG_CRC_SEED:    r_cfg.crc_seed    <= i_cfg_data[CRC_W-1:0];
                CFG_CRC_POLY:    r_cfg.crc_poly    <= i_cfg_data[CRC_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (i_rx.ready) begin
            r_in_vld <= i_rx.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rx.valid && i_rx.ready) begin
            r_in_byte <= i_rx.rx_byte;
        end
    end

    sfr_deframer u_deframer (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adv   (adv),
        .i_byte  (r_in_byte),
        .i_cfg   (r_cfg),
        .o_res   (n_out)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (adv) begin
            r_out_vld <= 1'b1;
        end else if (o_res.ready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_out <= n_out;
        end
    end

    assign o_res.valid = r_out_vld;
    assign o_res.data  = r_out;
endmodule

### rtl/core/sfr_checker.sv
// Port-level assertions for the stuffed frame receiver, bound to the top level.
// Depends on sfr_pkg and stuffed_frame_receiver_crc16.
module sfr_checker (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_out_valid,
    input  logic                 i_out_ready,
    input  sfr_pkg::t_sfr_result i_out_data
);
    import sfr_pkg::*;

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_out_data))
        else $error("result word dropped or changed while stalled");

    a_empty_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_data.byte_valid |->
            i_out_data.frame_byte == '0 && i_out_data.byte_index == '0)
        else $error("unstored word carries byte data");

    a_idle_drop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_data.event_res == EV_IDLE_DROP |-> !i_out_data.byte_valid)
        else $error("idle discard reports a stored byte");

    a_seq_bit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_data.sequence_bit |-> i_out_data.event_res == EV_FRAME_OK)
        else $error("sequence bit outside a good frame");

    a_length: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_data.payload_length != '0 |->
            i_out_data.event_res == EV_FRAME_OK || i_out_data.event_res == EV_CRC_ERR ||
            i_out_data.event_res == EV_ADDR_MISS)
        else $error("payload length reported without frame end");
endmodule

bind stuffed_frame_receiver_crc16 sfr_checker u_sfr_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_out_valid (o_res.valid),
    .i_out_ready (o_res.ready),
    .i_out_data  (o_res.data)
);

### sim/tb_stuffed_frame_receiver_crc16.sv
// Self-checking bench for stuffed_frame_receiver_crc16: a directed byte table, then random
// stuffed frames under several register settings, checked against a local deframer model.
// Depends on sfr_pkg, sfr_in_if, sfr_out_if and the receiver RTL.
module tb_stuffed_frame_receiver_crc16;
    import sfr_pkg::*;

    localparam int WATCHDOG_CYCLES = 200000;
    localparam int SUBPHASE_BYTES  = 100;
    localparam t_sfr_result BLANK_RES = '0;

    typedef struct {
        logic [BYTE_W-1:0] rx;
        bit                pinned;
        t_sfr_result       want;
    } t_dir_row;

    typedef struct {
        bit          pinned;
        t_sfr_result want;
    } t_pin;

    logic i_clk = 1'b0;
    logic i_rst_n;
    logic i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_idx;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    sfr_in_if  rx_if ();
    sfr_out_if res_if ();

    stuffed_frame_receiver_crc16 dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_rx       (rx_if),
        .o_res      (res_if),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    // deframer mirror
    t_sfr_cfg           cfg_m;
    logic [COUNT_W-1:0] fr_count;
    logic               fr_stuffed;
    logic [COUNT_W-1:0] fr_len;
    logic [CRC_W-1:0]   fr_crc;
    logic [CRC_W-1:0]   fr_rcv;
    logic [BYTE_W-1:0]  fr_addr;

    t_sfr_result pending_results [$];
    t_pin        table_pins [$];
    t_dir_row    dir_rows [24];
    int          err_count = 0;
    int          n_sent = 0;
    int          n_done = 0;
    int          framed_bytes = 0;
    int          send_idle_pct = 0;
    int          recv_stall_pct = 0;
    t_sfr_result pred_r, want_r, got_r;
    t_pin        pin_r;

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    function automatic logic [CRC_W-1:0] crc16_fold(input logic [CRC_W-1:0] crc,
                                                    input logic [BYTE_W-1:0] b);
        logic [CRC_W-1:0] r;
        r = crc ^ {b, 8'h00};
        for (int k = 0; k < 8; k++)
            r = r[15] ? ((r << 1) ^ cfg_m.crc_poly) : (r << 1);
        return r;
    endfunction

    function automatic logic [COUNT_W-1:0] deframe_store(input logic [BYTE_W-1:0] b);
        logic [COUNT_W-1:0] ix;
        ix = fr_count;
        if (ix == 9'd1) begin
            fr_addr = b;
            fr_crc  = crc16_fold(fr_crc, b);
        end else if (ix == 9'd2) begin
            fr_crc = crc16_fold(fr_crc, b);
            fr_len = {1'b0, b} + FRAME_OVERHEAD;
        end else if (ix >= 9'd3 && fr_len != '0) begin
            if ({1'b0, ix} + 10'd2 < {1'b0, fr_len})
                fr_crc = crc16_fold(fr_crc, b);
            else if ({1'b0, ix} + 10'd2 == {1'b0, fr_len})
                fr_rcv[7:0] = b;
            else
                fr_rcv[15:8] = b;
        end
        fr_count = ix + 9'd1;
        return ix;
    endfunction

    function automatic t_sfr_result deframe_step(input logic [BYTE_W-1:0] b);
        t_sfr_result r;
        logic [BYTE_W-1:0] s;
        logic keep;
        r = '0;
        s = cfg_m.start_byte;
        keep = 1'b0;
        if (fr_count == '0) begin
            if (b == s) begin
                fr_stuffed = 1'b0;
                fr_len     = '0;
                fr_crc     = cfg_m.crc_seed;
                fr_rcv     = '0;
                fr_addr    = '0;
                keep       = 1'b1;
            end else begin
                r.event_res = EV_IDLE_DROP;
            end
        end else begin
            if (fr_stuffed) begin
                fr_stuffed = 1'b0;
                if (b != s) begin
                    fr_count    = 9'd1;
                    fr_len      = '0;
                    fr_crc      = cfg_m.crc_seed;
                    fr_rcv      = '0;
                    r.event_res = EV_RESYNC;
                end
                keep = 1'b1;
            end else if (b == s) begin
                fr_stuffed = 1'b1;
            end else begin
                keep = 1'b1;
            end
        end
        if (keep) begin
            r.byte_index = deframe_store(b);
            r.byte_valid = 1'b1;
            r.frame_byte = b;
        end
        if (r.event_res != EV_IDLE_DROP && fr_len != '0 && fr_count == fr_len) begin
            r.payload_length = 8'(fr_len - FRAME_OVERHEAD);
            if ((fr_addr & s) != {1'b0, cfg_m.own_address}) begin
                r.event_res = EV_ADDR_MISS;
            end else if (fr_crc != fr_rcv) begin
                r.event_res = EV_CRC_ERR;
            end else begin
                r.event_res    = EV_FRAME_OK;
                r.sequence_bit = fr_addr[7];
            end
            fr_count   = '0;
            fr_stuffed = 1'b0;
        end
        return r;
    endfunction

    function automatic string fmt_res(input t_sfr_result r);
        return $sformatf("v=%0d byte=%02h idx=%0d ev=%0d seq=%0d len=%0d", r.byte_valid,
                         r.frame_byte, r.byte_index, r.event_res, r.sequence_bit,
                         r.payload_length);
    endfunction

    task automatic note_error(input string msg);
        err_count++;
        if (err_count <= 10)
            $display("%s", msg);
    endtask

    always @(posedge i_clk) begin
        res_if.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (rx_if.valid && rx_if.ready) begin
                pred_r = deframe_step(rx_if.rx_byte);
                pin_r  = table_pins.pop_front();
                pending_results.push_back(pin_r.pinned ? pin_r.want : pred_r);
            end
            if (res_if.valid && res_if.ready) begin
                got_r = res_if.data;
                if (pending_results.size() == 0) begin
                    note_error({"result with nothing expected: ", fmt_res(got_r)});
                end else begin
                    want_r = pending_results.pop_front();
                    if (got_r.byte_valid !== want_r.byte_valid ||
                        got_r.frame_byte !== want_r.frame_byte ||
                        got_r.byte_index !== want_r.byte_index ||
                        got_r.event_res !== want_r.event_res ||
                        got_r.sequence_bit !== want_r.sequence_bit ||
                        got_r.payload_length !== want_r.payload_length)
                        note_error($sformatf("result %0d mismatch: exp %s / got %s", n_done,
                                             fmt_res(want_r), fmt_res(got_r)));
                end
                n_done++;
            end
        end
    end

    task automatic send_byte(input logic [BYTE_W-1:0] b, input bit pinned,
                             input t_sfr_result want);
        t_pin p;
        while ($urandom_range(0, 99) < send_idle_pct) begin
            rx_if.valid <= 1'b0;
            @(posedge i_clk);
        end
        p.pinned = pinned;
        p.want   = want;
        table_pins.push_back(p);
        rx_if.valid   <= 1'b1;
        rx_if.rx_byte <= b;
        do @(posedge i_clk); while (!rx_if.ready);
        n_sent++;
    endtask

    task automatic drain();
        rx_if.valid <= 1'b0;
        while (n_done < n_sent) @(posedge i_clk);
    endtask

    task automatic load_cfg(input t_sfr_cfg c);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= CFG_START_BYTE;
        i_cfg_data <= CFG_DATA_W'(c.start_byte);
        @(posedge i_clk);
        i_cfg_idx  <= CFG_OWN_ADDRESS;
        i_cfg_data <= CFG_DATA_W'(c.own_address);
        @(posedge i_clk);
        i_cfg_idx  <= CFG_CRC_SEED;
        i_cfg_data <= c.crc_seed;
        @(posedge i_clk);
        i_cfg_idx  <= CFG_CRC_POLY;
        i_cfg_data <= c.crc_poly;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        cfg_m = c;
    endtask

    task automatic send_frame(input int force_len);
        logic [BYTE_W-1:0] s, a, len;
        logic [BYTE_W-1:0] body [$];
        logic [CRC_W-1:0]  c;
        int cut;
        s = cfg_m.start_byte;
        a = 8'($urandom);
        if (force_len >= 0 || $urandom_range(0, 99) < 88)
            a = (a & ~s) | ({1'b0, cfg_m.own_address} & s);
        if (force_len >= 0)
            len = 8'(force_len);
        else if ($urandom_range(0, 9) == 0)
            len = 8'($urandom_range(7, 40));
        else
            len = 8'($urandom_range(0, 6));
        body = '{a, len};
        for (int k = 0; k < len; k++)
            body.push_back(($urandom_range(0, 4) == 0) ? s : 8'($urandom));
        c = cfg_m.crc_seed;
        foreach (body[k])
            c = crc16_fold(c, body[k]);
        body.push_back(c[7:0]);
        body.push_back(c[15:8]);
        if (force_len < 0 && $urandom_range(0, 99) < 10)
            body[body.size() - 1 - $urandom_range(0, 1)] ^= 8'(1 << $urandom_range(0, 7));
        if (force_len < 0 && $urandom_range(0, 99) < 6) begin
            cut = $urandom_range(1, body.size() - 1);
            while (body.size() > cut)
                void'(body.pop_back());
        end
        send_byte(s, 1'b0, BLANK_RES);
        foreach (body[k]) begin
            if (body[k] == s)
                send_byte(s, 1'b0, BLANK_RES);
            send_byte(body[k], 1'b0, BLANK_RES);
            framed_bytes++;
        end
    endtask

    initial begin
        t_sfr_cfg plan [6];
        logic [CRC_W-1:0] c;
        int base;
        int n;

        i_rst_n       = 1'b0;
        i_cfg_we      = 1'b0;
        i_cfg_idx     = CFG_START_BYTE;
        i_cfg_data    = '0;
        rx_if.valid   = 1'b0;
        rx_if.rx_byte = '0;
        res_if.ready  = 1'b0;

        cfg_m      = '{START_BYTE_RST, OWN_ADDRESS_RST, CRC_SEED_RST, CRC_POLY_RST};
        fr_count   = '0;
        fr_stuffed = 1'b0;
        fr_len     = '0;
        fr_crc     = CRC_SEED_RST;
        fr_rcv     = '0;
        fr_addr    = '0;

        dir_rows = '{
            '{8'h00, 1'b1, '{1'b0, 8'h00, 9'd0, EV_IDLE_DROP, 1'b0, 8'h00}},
            '{8'hFF, 1'b1, '{1'b0, 8'h00, 9'd0, EV_IDLE_DROP, 1'b0, 8'h00}},
            '{8'h7F, 1'b1, '{1'b1, 8'h7F, 9'd0, EV_NONE, 1'b0, 8'h00}},
            '{8'h80, 1'b1, '{1'b1, 8'h80, 9'd1, EV_NONE, 1'b0, 8'h00}},
            '{8'h00, 1'b1, '{1'b1, 8'h00, 9'd2, EV_NONE, 1'b0, 8'h00}},
            '{8'h00, 1'b0, BLANK_RES},
            '{8'h00, 1'b0, BLANK_RES},
            '{8'h7F, 1'b1, '{1'b1, 8'h7F, 9'd0, EV_NONE, 1'b0, 8'h00}},
            '{8'h01, 1'b1, '{1'b1, 8'h01, 9'd1, EV_NONE, 1'b0, 8'h00}},
            '{8'h7F, 1'b1, BLANK_RES},
            '{8'h7F, 1'b1, '{1'b1, 8'h7F, 9'd2, EV_NONE, 1'b0, 8'h00}},
            '{8'h7F, 1'b1, BLANK_RES},
            '{8'h05, 1'b1, '{1'b1, 8'h05, 9'd1, EV_RESYNC, 1'b0, 8'h00}},
            '{8'h02, 1'b1, '{1'b1, 8'h02, 9'd2, EV_NONE, 1'b0, 8'h00}},
            '{8'h7F, 1'b1, BLANK_RES},
            '{8'h7F, 1'b1, '{1'b1, 8'h7F, 9'd3, EV_NONE, 1'b0, 8'h00}},
            '{8'hAA, 1'b1, '{1'b1, 8'hAA, 9'd4, EV_NONE, 1'b0, 8'h00}},
            '{8'h00, 1'b1, '{1'b1, 8'h00, 9'd5, EV_NONE, 1'b0, 8'h00}},
            '{8'h00, 1'b1, '{1'b1, 8'h00, 9'd6, EV_ADDR_MISS, 1'b0, 8'h02}},
            '{8'h7F, 1'b1, '{1'b1, 8'h7F, 9'd0, EV_NONE, 1'b0, 8'h00}},
            '{8'h00, 1'b1, '{1'b1, 8'h00, 9'd1, EV_NONE, 1'b0, 8'h00}},
            '{8'h00, 1'b1, '{1'b1, 8'h00, 9'd2, EV_NONE, 1'b0, 8'h00}},
            '{8'h12, 1'b1, '{1'b1, 8'h12, 9'd3, EV_NONE, 1'b0, 8'h00}},
            '{8'h34, 1'b0, BLANK_RES}
        };
        c = crc16_fold(crc16_fold(CRC_SEED_RST, 8'h80), 8'h00);
        dir_rows[5].rx = c[7:0];
        dir_rows[6].rx = c[15:8];

        plan[0] = cfg_m;
        plan[1] = '{8'hFF, 7'h7F, 16'h0000, 16'h1021};
        plan[2] = '{8'h00, 7'h00, 16'hFFFF, 16'hFFFF};
        plan[3] = '{8'h80, 7'h00, 16'h1D0F, 16'h0000};
        for (int k = 4; k < 6; k++) begin
            plan[k].start_byte  = 8'($urandom);
            plan[k].own_address = 7'($urandom) & plan[k].start_byte[6:0];
            plan[k].crc_seed    = 16'($urandom);
            plan[k].crc_poly    = 16'($urandom);
        end

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        send_idle_pct  = 19;
        recv_stall_pct = 79;
        foreach (dir_rows[k])
            send_byte(dir_rows[k].rx, dir_rows[k].pinned, dir_rows[k].want);

        for (int sp = 0; sp < 6; sp++) begin
            send_idle_pct  = (sp / 2 == 0) ? 19 : (sp / 2 == 1) ? 79 : 0;
            recv_stall_pct = (sp / 2 == 0) ? 79 : (sp / 2 == 1) ? 19 : 0;
            if (sp > 0) begin
                drain();
                load_cfg(plan[sp]);
            end
            if (sp == 5)
                send_frame(255);
            base = framed_bytes;
            while (framed_bytes - base < SUBPHASE_BYTES) begin
                if ($urandom_range(0, 99) < 15) begin
                    n = $urandom_range(1, 4);
                    repeat (n) send_byte(8'($urandom), 1'b0, BLANK_RES);
                end
                send_frame(-1);
            end
        end

        drain();
        repeat (8) @(posedge i_clk);
        if (pending_results.size() != 0)
            note_error($sformatf("%0d results never arrived", pending_results.size()));
        if (err_count == 0)
            $display("tb_stuffed_frame_receiver_crc16: clean");
        else
            $display("tb_stuffed_frame_receiver_crc16: errors");
        $finish;
    end

    initial begin
        #(WATCHDOG_CYCLES * 8);
        $display("tb_stuffed_frame_receiver_crc16: errors");
        $finish;
    end

endmodule
